// ----- hdl/drm_pkg.sv -----
// Shared constants, types and helpers for the domain rule matcher.
`timescale 1ns / 1ps
package drm_pkg;

  localparam int DEF_RULE_SLOTS = 64;
  localparam int DEF_PAT_LEN    = 48;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_INS   = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [1:0] REPLY_QUERY = 2'd0;
  localparam logic [1:0] REPLY_INS   = 2'd1;
  localparam logic [1:0] REPLY_CLEAR = 2'd2;

  localparam logic [1:0] KIND_BLOCK     = 2'd0;
  localparam logic [1:0] KIND_ALLOW     = 2'd1;
  localparam logic [1:0] KIND_TELEMETRY = 2'd2;

  localparam logic [7:0] CHAR_STAR = 8'h2A;
  localparam logic [7:0] CHAR_DOT  = 8'h2E;

  // controller -> datapath commands
  typedef struct packed {
    logic clear;   // empty the table
    logic ins;     // take a pattern byte
    logic qload;   // latch a query byte
    logic rd_en;   // read one rule row for the scan
    logic finish;  // close the query byte
  } drm_ctl_t;

  // fold ASCII upper case to lower case
  function automatic logic [7:0] fold(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'd32;
    end
    return c;
  endfunction

endpackage

// ----- hdl/drm_ctrl.sv -----
// Sequencer: decodes commands and walks the rule table for each query byte.
`timescale 1ns / 1ps
module drm_ctrl import drm_pkg::*; #(
  parameter int RULE_SLOTS = DEF_RULE_SLOTS,
  parameter int IDX_W      = 6,
  parameter int TOT_W      = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       cmd,
  input  logic [TOT_W-1:0] rule_count,
  output logic             busy,
  output drm_ctl_t         ctl,
  output logic [IDX_W-1:0] rd_addr
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN} state_t;

  state_t           state;
  logic [IDX_W-1:0] idx;
  logic [TOT_W-1:0] last_idx;

  assign busy     = (state != S_IDLE);
  assign rd_addr  = idx;
  assign last_idx = rule_count - TOT_W'(1);

  always_comb begin
    ctl = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.clear = (cmd == CMD_CLEAR);
          ctl.ins   = (cmd == CMD_INS);
          ctl.qload = (cmd == CMD_QUERY);
        end
      end
      S_SCAN: begin
        if (rule_count == '0) begin
          ctl.finish = 1'b1;
        end else begin
          ctl.rd_en = 1'b1;
        end
      end
      S_DRAIN: ctl.finish = 1'b1;
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          idx <= '0;
          if (start && cmd == CMD_QUERY) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rule_count == '0) begin
            state <= S_IDLE;
          end else if (TOT_W'(idx) == last_idx) begin
            state <= S_DRAIN;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_DRAIN: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/drm_datapath.sv -----
// Rule store, per-rule suffix tracking and result registers.
`timescale 1ns / 1ps
module drm_datapath import drm_pkg::*; #(
  parameter int RULE_SLOTS = DEF_RULE_SLOTS,
  parameter int PAT_LEN    = DEF_PAT_LEN,
  parameter int IDX_W      = 6,
  parameter int TOT_W      = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  drm_ctl_t         ctl,
  input  logic [IDX_W-1:0] rd_addr,
  input  logic [7:0]       data_byte,
  input  logic [1:0]       rule_kind,
  input  logic             last_byte,
  output logic [TOT_W-1:0] rule_count,
  output logic             done,
  output logic [1:0]       reply_type,
  output logic             blocked_hit,
  output logic             allowed_hit,
  output logic             telemetry_hit,
  output logic             insert_ok,
  output logic [6:0]       rules_held
);

  localparam int LEN_W = $clog2(PAT_LEN + 1);
  localparam int TL_W  = LEN_W + 1;
  localparam int TGT_N = PAT_LEN + 1;
  localparam int ROW_W = PAT_LEN * 8 + LEN_W + 3;

  typedef logic [PAT_LEN-1:0][7:0] chars_t;

  logic [ROW_W-1:0] rule_mem [RULE_SLOTS];
  logic [TGT_N-1:0] prog_mem [RULE_SLOTS];

  logic [TOT_W-1:0] total;
  logic [LEN_W-1:0] pos;
  logic             ovf;
  logic             qcs;
  chars_t           stage;
  logic [7:0]       qchar;
  logic             qlast;
  logic [2:0]       hit_acc;

  logic [ROW_W-1:0] row_rd;
  logic [TGT_N-1:0] prog_rd;
  logic             pv;
  logic [IDX_W-1:0] pv_addr;

  // insert path
  chars_t           chars_new;
  logic             pos_ok;
  logic [LEN_W-1:0] pos_next;
  logic             ovf_next;
  logic             ins_ok;
  logic             wild_new;

  always_comb begin
    chars_new = stage;
    for (int k = 0; k < PAT_LEN; k++) begin
      if (pos == LEN_W'(k)) chars_new[k] = data_byte;
    end
    pos_ok   = (pos < LEN_W'(PAT_LEN));
    pos_next = pos_ok ? pos + LEN_W'(1) : pos;
    ovf_next = ovf | ~pos_ok;
    ins_ok   = !ovf_next && (pos_next != '0) && (total < TOT_W'(RULE_SLOTS))
               && (rule_kind <= KIND_TELEMETRY);
    wild_new = (pos_next >= LEN_W'(2)) && (chars_new[0] == CHAR_STAR)
               && (chars_new[1] == CHAR_DOT);
  end

  // scan path: one rule row
  chars_t           r_ch;
  logic [LEN_W-1:0] r_len;
  logic [1:0]       r_kind;
  logic             r_wild;
  logic [TL_W-1:0]  tl;
  logic [TGT_N-1:0] eff;
  logic [TGT_N-1:0] nw;
  logic [7:0]       tgt [TGT_N];
  logic             r_hit;
  logic [2:0]       hit_now;

  always_comb begin
    {r_ch, r_len, r_kind, r_wild} = row_rd;
    tl = r_wild ? TL_W'(r_len) - TL_W'(1) : TL_W'(r_len) + TL_W'(1);
    for (int j = 0; j < TGT_N; j++) begin
      if (r_wild) begin
        tgt[j] = (j + 1 < PAT_LEN) ? fold(r_ch[(j + 1 < PAT_LEN) ? j + 1 : 0]) : 8'd0;
      end else begin
        tgt[j] = (j == 0) ? CHAR_DOT : fold(r_ch[(j > 0) ? j - 1 : 0]);
      end
    end
    // before the first byte only the virtual leading dot is live
    eff    = qcs ? prog_rd : TGT_N'(1);
    nw     = '0;
    nw[0]  = (qchar == CHAR_DOT) && (r_wild || qcs);
    for (int j = 1; j < TGT_N; j++) begin
      nw[j] = eff[j-1] && (qchar == tgt[j]) && (TL_W'(j) < tl);
    end
    r_hit = 1'b0;
    for (int j = 0; j < TGT_N; j++) begin
      if (TL_W'(j) == tl - TL_W'(1)) r_hit = nw[j];
    end
    hit_now = '0;
    if (pv && qlast && r_hit) begin
      case (r_kind)
        KIND_BLOCK:     hit_now[0] = 1'b1;
        KIND_ALLOW:     hit_now[1] = 1'b1;
        KIND_TELEMETRY: hit_now[2] = 1'b1;
        default:        hit_now = '0;
      endcase
    end
  end

  assign rule_count = total;

  // memories
  always_ff @(posedge clk) begin
    if (ctl.ins && last_byte && ins_ok) begin
      rule_mem[total[IDX_W-1:0]] <= {chars_new, pos_next, rule_kind, wild_new};
      prog_mem[total[IDX_W-1:0]] <= '0;
    end else if (pv) begin
      prog_mem[pv_addr] <= nw;
    end
    if (ctl.rd_en) begin
      row_rd  <= rule_mem[rd_addr];
      prog_rd <= prog_mem[rd_addr];
    end
    pv_addr <= rd_addr;
    if (ctl.ins && pos_ok) stage <= chars_new;
    if (ctl.qload) begin
      qchar <= fold(data_byte);
      qlast <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total         <= '0;
      pos           <= '0;
      ovf           <= 1'b0;
      qcs           <= 1'b0;
      hit_acc       <= '0;
      pv            <= 1'b0;
      done          <= 1'b0;
      reply_type    <= REPLY_QUERY;
      blocked_hit   <= 1'b0;
      allowed_hit   <= 1'b0;
      telemetry_hit <= 1'b0;
      insert_ok     <= 1'b0;
      rules_held    <= '0;
    end else begin
      pv            <= ctl.rd_en;
      done          <= 1'b0;
      blocked_hit   <= 1'b0;
      allowed_hit   <= 1'b0;
      telemetry_hit <= 1'b0;
      insert_ok     <= 1'b0;
      if (pv) hit_acc <= hit_acc | hit_now;
      if (ctl.clear) begin
        total      <= '0;
        pos        <= '0;
        ovf        <= 1'b0;
        qcs        <= 1'b0;
        hit_acc    <= '0;
        done       <= 1'b1;
        reply_type <= REPLY_CLEAR;
        rules_held <= '0;
      end
      if (ctl.ins) begin
        if (last_byte) begin
          pos        <= '0;
          ovf        <= 1'b0;
          done       <= 1'b1;
          reply_type <= REPLY_INS;
          insert_ok  <= ins_ok;
          if (ins_ok) begin
            total      <= total + TOT_W'(1);
            rules_held <= 7'(total + TOT_W'(1));
          end else begin
            rules_held <= 7'(total);
          end
        end else begin
          pos <= pos_next;
          ovf <= ovf_next;
        end
      end
      if (ctl.finish) begin
        qcs <= 1'b1;
        if (qlast) begin
          qcs           <= 1'b0;
          hit_acc       <= '0;
          done          <= 1'b1;
          reply_type    <= REPLY_QUERY;
          blocked_hit   <= hit_acc[0] | hit_now[0];
          allowed_hit   <= hit_acc[1] | hit_now[1];
          telemetry_hit <= hit_acc[2] | hit_now[2];
          rules_held    <= 7'(total);
        end
      end
    end
  end

endmodule

// ----- hdl/domain_rule_matcher_core.sv -----
// Top level of the domain rule matcher: sequencer plus datapath.
//
// Usage: drive cmd/data_byte/rule_kind/last_byte with start; a beat is taken
// on a clock edge with start high and busy low.
//   cmd clear : empties the table; the clear ack follows in the next cycle.
//   cmd insert: one pattern byte per beat; on the final byte an insert ack
//               (insert_ok, rules_held) follows in the next cycle.
//   cmd query : one name byte per beat. Every stored rule is visited in turn
//               through the rule memory read port, so a query byte holds busy
//               after acceptance through the scan of the stored rules and a
//               drain state (only the scan state when empty). The result of the
//               final byte shows with done when busy drops.
// Results: done is high for exactly one cycle with the reply fields; the
// receiver cannot stall, so nothing is held back.
// Reset (rst, synchronous): table empty, no partial pattern or query. The
// rule memories are not swept; entries are only read after they are written.
`timescale 1ns / 1ps
module domain_rule_matcher_core import drm_pkg::*; #(
  parameter int RULE_SLOTS = DEF_RULE_SLOTS,
  parameter int PAT_LEN    = DEF_PAT_LEN
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] cmd,
  input  logic [7:0] data_byte,
  input  logic [1:0] rule_kind,
  input  logic       last_byte,
  output logic       done,
  output logic [1:0] reply_type,
  output logic       blocked_hit,
  output logic       allowed_hit,
  output logic       telemetry_hit,
  output logic       insert_ok,
  output logic [6:0] rules_held
);

  localparam int IDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int TOT_W = $clog2(RULE_SLOTS + 1);

  drm_ctl_t         ctl;
  logic [IDX_W-1:0] rd_addr;
  logic [TOT_W-1:0] rule_count;

  drm_ctrl #(.RULE_SLOTS(RULE_SLOTS), .IDX_W(IDX_W), .TOT_W(TOT_W)) u_ctrl (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd), .rule_count(rule_count),
    .busy(busy), .ctl(ctl), .rd_addr(rd_addr)
  );

  drm_datapath #(.RULE_SLOTS(RULE_SLOTS), .PAT_LEN(PAT_LEN), .IDX_W(IDX_W),
                 .TOT_W(TOT_W)) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .rd_addr(rd_addr),
    .data_byte(data_byte), .rule_kind(rule_kind), .last_byte(last_byte),
    .rule_count(rule_count), .done(done), .reply_type(reply_type),
    .blocked_hit(blocked_hit), .allowed_hit(allowed_hit),
    .telemetry_hit(telemetry_hit), .insert_ok(insert_ok),
    .rules_held(rules_held)
  );

endmodule

// ----- hdl/drm_checker.sv -----
// Port-level checks for the domain rule matcher, bound to the top level.
`timescale 1ns / 1ps
module drm_checker import drm_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] cmd,
  input logic [7:0] data_byte,
  input logic [1:0] rule_kind,
  input logic       last_byte,
  input logic       done,
  input logic [1:0] reply_type,
  input logic       blocked_hit,
  input logic       allowed_hit,
  input logic       telemetry_hit,
  input logic       insert_ok,
  input logic [6:0] rules_held
);

  a_clear_ack: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd == CMD_CLEAR |=> done && reply_type == REPLY_CLEAR
      && rules_held == 7'd0)
    else $error("clear beat without clear ack");

  a_ins_ack: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd == CMD_INS && last_byte |=> done && reply_type == REPLY_INS)
    else $error("final pattern beat without insert ack");

  a_hits_only_query: assert property (@(posedge clk) disable iff (rst)
    done && reply_type != REPLY_QUERY |-> !blocked_hit && !allowed_hit && !telemetry_hit)
    else $error("hit flags on a non-query reply");

  a_ok_only_ins: assert property (@(posedge clk) disable iff (rst)
    done && reply_type != REPLY_INS |-> !insert_ok)
    else $error("insert_ok on a non-insert reply");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd == CMD_QUERY |=> busy && !done)
    else $error("query beat did not hold busy");

endmodule

bind domain_rule_matcher_core drm_checker u_drm_checker (.*);

// ----- test/tb.sv -----
// Self-checking testbench for domain_rule_matcher_core: directed and random beats.
`timescale 1ns / 1ps
module tb;
  import drm_pkg::*;

  localparam int SLOTS = DEF_RULE_SLOTS;
  localparam int PLEN = DEF_PAT_LEN;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [1:0] CMD_NONE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] cmd = CMD_CLEAR;
  logic [7:0] data_byte = 8'h00;
  logic [1:0] rule_kind = KIND_BLOCK;
  logic last_byte = 1'b0;
  logic busy, done, blocked_hit, allowed_hit, telemetry_hit, insert_ok;
  logic [1:0] reply_type;
  logic [6:0] rules_held;

  domain_rule_matcher_core i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .data_byte(data_byte), .rule_kind(rule_kind), .last_byte(last_byte),
    .done(done), .reply_type(reply_type), .blocked_hit(blocked_hit),
    .allowed_hit(allowed_hit), .telemetry_hit(telemetry_hit),
    .insert_ok(insert_ok), .rules_held(rules_held)
  );

  always #10 clk = ~clk;

  typedef struct packed {
    logic [1:0] rtype;
    logic       blk;
    logic       alw;
    logic       tel;
    logic       ok;
    logic [6:0] held;
  } reply_t;

  reply_t replies_due[$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;

  // shadow copy of the rule table and the per-rule match tracking
  logic [7:0]  sh_chars [SLOTS][PLEN];
  int          sh_len   [SLOTS];
  logic [1:0]  sh_kind  [SLOTS];
  logic        sh_wild  [SLOTS];
  logic [63:0] sh_prog  [SLOTS];
  logic        sh_exact [SLOTS];
  int          sh_total = 0;
  int          sh_pos = 0;
  logic        sh_ovf = 1'b0;
  logic        sh_seen = 1'b0;

  byte unsigned word_q[$];

  function automatic logic [7:0] lower(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  // character j of the dotted suffix a rule follows
  function automatic logic [7:0] suffix_char(int r, int j);
    int idx;
    if (sh_wild[r]) idx = j + 1;
    else if (j == 0) return CHAR_DOT;
    else idx = j - 1;
    if (idx >= PLEN) return 8'h00;
    return lower(sh_chars[r][idx]);
  endfunction

  function automatic void restart_tracking();
    for (int r = 0; r < SLOTS; r++) begin
      sh_prog[r] = '0;
      sh_exact[r] = 1'b1;
    end
    sh_seen = 1'b0;
  endfunction

  // advance the shadow table by one accepted beat; queue any reply it causes
  function automatic void match_beat(logic [1:0] c, logic [7:0] b, logic [1:0] k, logic l);
    reply_t rp;
    logic [7:0] ch;
    logic [63:0] eff, nw;
    int tl;
    rp = '0;
    if (c == CMD_CLEAR) begin
      sh_total = 0; sh_pos = 0; sh_ovf = 1'b0;
      restart_tracking();
      rp.rtype = REPLY_CLEAR;
      replies_due.push_back(rp);
    end else if (c == CMD_INS) begin
      if (sh_pos < PLEN) begin
        if (sh_total < SLOTS) sh_chars[sh_total][sh_pos] = b;
        sh_pos++;
      end else sh_ovf = 1'b1;
      if (l) begin
        rp.ok = !sh_ovf && sh_pos > 0 && sh_total < SLOTS && k <= KIND_TELEMETRY;
        if (rp.ok) begin
          sh_len[sh_total] = sh_pos;
          sh_kind[sh_total] = k;
          sh_wild[sh_total] = sh_pos >= 2 && sh_chars[sh_total][0] == CHAR_STAR &&
                              sh_chars[sh_total][1] == CHAR_DOT;
          sh_prog[sh_total] = '0;
          sh_exact[sh_total] = !sh_seen;
          sh_total++;
        end
        sh_pos = 0; sh_ovf = 1'b0;
        rp.rtype = REPLY_INS;
        rp.held = sh_total[6:0];
        replies_due.push_back(rp);
      end
    end else if (c == CMD_QUERY) begin
      ch = lower(b);
      for (int r = 0; r < sh_total; r++) begin
        tl = sh_wild[r] ? sh_len[r] - 1 : sh_len[r] + 1;
        eff = sh_prog[r] | {63'd0, sh_exact[r]};
        nw = '0;
        if (ch == CHAR_DOT && (sh_wild[r] || sh_seen)) nw[0] = 1'b1;
        for (int j = 1; j < tl && j < 64; j++)
          if (eff[j-1] && ch == suffix_char(r, j)) nw[j] = 1'b1;
        sh_prog[r] = nw;
        sh_exact[r] = 1'b0;
      end
      sh_seen = 1'b1;
      if (l) begin
        rp.rtype = REPLY_QUERY;
        for (int r = 0; r < sh_total; r++) begin
          tl = sh_wild[r] ? sh_len[r] - 1 : sh_len[r] + 1;
          if (tl >= 1 && sh_prog[r][tl-1]) begin
            case (sh_kind[r])
              KIND_BLOCK: rp.blk = 1'b1;
              KIND_ALLOW: rp.alw = 1'b1;
              default:    rp.tel = 1'b1;
            endcase
          end
        end
        rp.held = sh_total[6:0];
        restart_tracking();
        replies_due.push_back(rp);
      end
    end
  endfunction

  // one beat: optional sender gap, then hold start until the block takes it
  task automatic send_beat(logic [1:0] c, logic [7:0] b, logic [1:0] k, logic l);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c; data_byte <= b; rule_kind <= k; last_byte <= l;
    do @(negedge clk); while (busy);
    @(posedge clk);
    match_beat(c, b, k, l);
  endtask

  // stream the word buffer as pattern or query bytes
  task automatic send_word(logic [1:0] c, logic [1:0] k);
    for (int i = 0; i < word_q.size(); i++)
      send_beat(c, word_q[i], k, i == word_q.size() - 1);
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) word_q.push_back(s[i]);
  endtask

  task automatic say_text(logic [1:0] c, logic [1:0] k, string s);
    word_q.delete();
    put_text(s);
    send_word(c, k);
  endtask

  // random dotted name from a small label set so suffixes collide often
  task automatic build_name(bit wild);
    string labels [8] = '{"a", "Ex", "com", "net", "ab", "x", "io", "AD"};
    int n;
    word_q.delete();
    if (wild) put_text("*.");
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      if (i > 0 || ($urandom_range(0, 15) == 0)) word_q.push_back(CHAR_DOT);
      put_text(labels[$urandom_range(0, 7)]);
    end
    if ($urandom_range(0, 9) == 0)
      word_q[$urandom_range(0, word_q.size() - 1)] = 8'($urandom_range(0, 255));
  endtask

  task automatic test_directed();
    idle_pct = 0;
    send_beat(CMD_CLEAR, 8'h00, KIND_BLOCK, 1'b0);
    say_text(CMD_INS, KIND_BLOCK, "example.com");
    say_text(CMD_INS, KIND_ALLOW, "*.ads.net");
    say_text(CMD_INS, KIND_TELEMETRY, "Tracker.IO");
    send_beat(CMD_NONE, 8'hFF, 2'd3, 1'b1);          // unused command, no reply
    say_text(CMD_QUERY, KIND_BLOCK, "EXAMPLE.com");   // exact
    say_text(CMD_QUERY, KIND_BLOCK, "a.example.com"); // dotted suffix
    say_text(CMD_QUERY, KIND_BLOCK, "xexample.com");  // no dot boundary
    say_text(CMD_QUERY, KIND_BLOCK, ".example.com");  // nothing before dot
    say_text(CMD_QUERY, KIND_BLOCK, "ads.net");       // wildcard bare suffix
    say_text(CMD_QUERY, KIND_BLOCK, ".ads.net");      // wildcard leading dot
    say_text(CMD_QUERY, KIND_BLOCK, "q.tracker.io");
    send_beat(CMD_INS, 8'h00, 2'd3, 1'b1);            // bad kind, rejected
    send_beat(CMD_INS, 8'h00, KIND_BLOCK, 1'b1);      // zero byte is a character
    send_beat(CMD_QUERY, 8'h00, KIND_BLOCK, 1'b1);
    word_q.delete();
    for (int i = 0; i < PLEN + 1; i++) word_q.push_back("z");
    send_word(CMD_INS, KIND_BLOCK);                   // too long
    word_q.pop_back();
    send_word(CMD_INS, KIND_ALLOW);                   // longest accepted
    send_word(CMD_QUERY, KIND_BLOCK);
    // rule stored mid-query only sees later bytes
    send_beat(CMD_QUERY, "b", KIND_BLOCK, 1'b0);
    say_text(CMD_INS, KIND_TELEMETRY, "b.c");
    say_text(CMD_QUERY, KIND_BLOCK, ".b.c");
    // fill the table, then one more is refused
    while (sh_total < SLOTS) send_beat(CMD_INS, "m", KIND_BLOCK, 1'b1);
    send_beat(CMD_INS, "m", KIND_BLOCK, 1'b1);
    send_beat(CMD_QUERY, "M", KIND_BLOCK, 1'b1);
    send_beat(CMD_CLEAR, 8'h00, KIND_BLOCK, 1'b1);
  endtask

  task automatic test_random(int pct, int beats);
    int sent, pick;
    idle_pct = pct;
    sent = 0;
    while (sent < beats) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_beat(CMD_CLEAR, 8'($urandom), 2'($urandom), 1'($urandom));
        sent++;
      end else if (pick < 6) begin
        send_beat(CMD_NONE, 8'($urandom), 2'($urandom), 1'($urandom));
      end else if (pick < 9) begin
        // mid-query insert
        send_beat(CMD_QUERY, 8'($urandom), 2'($urandom), 1'b0);
        build_name($urandom_range(0, 1));
        send_word(CMD_INS, 2'($urandom_range(0, 2)));
        sent += 1 + word_q.size();
      end else if (pick < 11) begin
        word_q.delete();
        repeat ($urandom_range(PLEN - 2, PLEN + 3)) word_q.push_back(8'($urandom));
        send_word(CMD_INS, 2'($urandom));
        sent += word_q.size();
      end else if (pick < 40) begin
        build_name($urandom_range(0, 2) == 0);
        send_word(CMD_INS, ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2)));
        sent += word_q.size();
      end else begin
        build_name(1'b0);
        send_word(CMD_QUERY, 2'($urandom));
        sent += word_q.size();
      end
      // keep the table from sitting full
      if (sh_total == SLOTS && $urandom_range(0, 3) == 0) begin
        send_beat(CMD_CLEAR, 8'h00, KIND_BLOCK, 1'b0);
        sent++;
      end
    end
  endtask

  // reply checker: a beat on done must match the oldest queued reply
  always @(negedge clk) begin
    reply_t want;
    if (!rst && done) begin
      if (replies_due.size() == 0) begin
        $display("%0t unexpected reply: expected none, actual type %0d held %0d",
                 $time, reply_type, rules_held);
        errors++;
      end else begin
        want = replies_due.pop_front();
        if (want != {reply_type, blocked_hit, allowed_hit, telemetry_hit, insert_ok, rules_held}) begin
          $display("%0t reply mismatch: expected type %0d b%0d a%0d t%0d ok%0d held %0d, actual type %0d b%0d a%0d t%0d ok%0d held %0d",
                   $time, want.rtype, want.blk, want.alw, want.tel, want.ok, want.held,
                   reply_type, blocked_hit, allowed_hit, telemetry_hit, insert_ok, rules_held);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    restart_tracking();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(12, 400);
    test_random(69, 400);
    test_random(0, 400);
    start <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
